// File: src/srpg_pkg.sv
// Package: shared types, register map and reset values for the stepper ramp pulse generator.
`default_nettype none
package srpg_pkg;

  localparam int unsigned NUM_MOTORS_DEF = 6;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WAKE_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_HALF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HALF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_STEPS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_TICKS   = 3'd5;

  localparam logic [15:0] WAKE_TICKS_RST  = 16'd2000;
  localparam logic [15:0] START_HALF_RST  = 16'd150;
  localparam logic [15:0] MIN_HALF_RST    = 16'd75;
  localparam logic [15:0] TOTAL_STEPS_RST = 16'd1600;
  localparam logic [15:0] RAMP_STEPS_RST  = 16'd1120;
  localparam logic [15:0] TAIL_TICKS_RST  = 16'd1000;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [2:0] motor_index;
    logic       direction;
  } in_t;

  typedef struct packed {
    logic [2:0] motor_sel;
    logic       driver_enabled;
    logic       dir_level;
    logic       step_level;
    logic       busy_res;
    logic       done_res;
  } out_t;

  typedef struct packed {
    logic [15:0] wake_ticks;
    logic [15:0] start_half_period;
    logic [15:0] min_half_period;
    logic [15:0] total_steps;
    logic [15:0] ramp_steps;
    logic [15:0] tail_ticks;
  } cfg_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_WAKE = 5'b00010,
    PH_HIGH = 5'b00100,
    PH_LOW  = 5'b01000,
    PH_TAIL = 5'b10000
  } phase_t;

endpackage
`default_nettype wire

// File: src/srpg_cfg_regs.sv
// Configuration register file of the stepper ramp pulse generator.
`default_nettype none
module srpg_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [srpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [srpg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output srpg_pkg::cfg_t                         cfg
);

  srpg_pkg::cfg_t cfg_r;
  srpg_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        srpg_pkg::REG_WAKE_TICKS:  cfg_nxt.wake_ticks        = cfg_wdata;
        srpg_pkg::REG_START_HALF:  cfg_nxt.start_half_period = cfg_wdata;
        srpg_pkg::REG_MIN_HALF:    cfg_nxt.min_half_period   = cfg_wdata;
        srpg_pkg::REG_TOTAL_STEPS: cfg_nxt.total_steps       = cfg_wdata;
        srpg_pkg::REG_RAMP_STEPS:  cfg_nxt.ramp_steps        = cfg_wdata;
        srpg_pkg::REG_TAIL_TICKS:  cfg_nxt.tail_ticks        = cfg_wdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wake_ticks        <= srpg_pkg::WAKE_TICKS_RST;
      cfg_r.start_half_period <= srpg_pkg::START_HALF_RST;
      cfg_r.min_half_period   <= srpg_pkg::MIN_HALF_RST;
      cfg_r.total_steps       <= srpg_pkg::TOTAL_STEPS_RST;
      cfg_r.ramp_steps        <= srpg_pkg::RAMP_STEPS_RST;
      cfg_r.tail_ticks        <= srpg_pkg::TAIL_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: src/stepper_ramp_pulse_generator.sv
// Top level: stepper motor step burst generator with a linear acceleration ramp.
// Every input word (a one-microsecond tick or a start request) produces exactly one
// output word showing the motor lines after that word. While no result stalls, one
// word is accepted per clock cycle, set by a single pass through the phase sequencer
// into the output register; the result appears in the cycle after its word. in_ready
// is !out_valid || out_ready; input stalls only while a result waits to be taken.
// A start latches motor and direction, waits wake_ticks, emits total_steps pulses whose
// half period ramps down by one per pulse toward min_half_period for the first
// ramp_steps pulses, waits tail_ticks and then releases the driver with done_res set.
// Starts while busy or naming a motor index at or above NUM_MOTORS are ignored.
`default_nettype none
module stepper_ramp_pulse_generator #(
  parameter int unsigned NUM_MOTORS = srpg_pkg::NUM_MOTORS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire srpg_pkg::in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output srpg_pkg::out_t                         out_data,
  input  wire logic                              cfg_we,
  input  wire logic [srpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [srpg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  srpg_pkg::cfg_t   cfg;
  srpg_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic [15:0]      half_r, half_nxt;
  logic [15:0]      pidx_r, pidx_nxt;
  logic [2:0]       motor_r, motor_nxt;
  logic             dir_r, dir_nxt;
  logic             done;
  logic             accept;
  logic [16:0]      next_idx;
  logic             motor_ok;
  logic             out_valid_r;
  srpg_pkg::out_t   out_data_r, out_data_nxt;

  srpg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign next_idx = {1'b0, pidx_r} + 17'd1;
  assign motor_ok = {1'b0, in_data.motor_index} < 4'(NUM_MOTORS);

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    half_nxt  = half_r;
    pidx_nxt  = pidx_r;
    motor_nxt = motor_r;
    dir_nxt   = dir_r;
    done      = 1'b0;
    if (in_data.req_type == srpg_pkg::REQ_START) begin
      if (phase_r == srpg_pkg::PH_IDLE && motor_ok) begin
        motor_nxt = in_data.motor_index;
        dir_nxt   = in_data.direction;
        half_nxt  = cfg.start_half_period;
        pidx_nxt  = 16'd0;
        if (cfg.wake_ticks == 16'd0) begin
          phase_nxt = srpg_pkg::PH_HIGH;
          tick_nxt  = cfg.start_half_period;
        end else begin
          phase_nxt = srpg_pkg::PH_WAKE;
          tick_nxt  = cfg.wake_ticks;
        end
      end
    end else if (phase_r != srpg_pkg::PH_IDLE) begin
      if (tick_r > 16'd1) begin
        tick_nxt = tick_r - 16'd1;
      end else begin
        unique case (phase_r)
          srpg_pkg::PH_WAKE: begin
            phase_nxt = srpg_pkg::PH_HIGH;
            tick_nxt  = half_r;
          end
          srpg_pkg::PH_HIGH: begin
            phase_nxt = srpg_pkg::PH_LOW;
            tick_nxt  = half_r;
          end
          srpg_pkg::PH_LOW: begin
            if (half_r > cfg.min_half_period && pidx_r < cfg.ramp_steps) begin
              half_nxt = half_r - 16'd1;
            end
            pidx_nxt = next_idx[15:0];
            if (next_idx >= {1'b0, cfg.total_steps}) begin
              if (cfg.tail_ticks == 16'd0) begin
                phase_nxt = srpg_pkg::PH_IDLE;
                tick_nxt  = 16'd0;
                done      = 1'b1;
              end else begin
                phase_nxt = srpg_pkg::PH_TAIL;
                tick_nxt  = cfg.tail_ticks;
              end
            end else begin
              phase_nxt = srpg_pkg::PH_HIGH;
              tick_nxt  = half_nxt;
            end
          end
          srpg_pkg::PH_TAIL: begin
            phase_nxt = srpg_pkg::PH_IDLE;
            tick_nxt  = 16'd0;
            done      = 1'b1;
          end
          default: begin
            phase_nxt = srpg_pkg::PH_IDLE;
            tick_nxt  = 16'd0;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_data_nxt.motor_sel      = motor_nxt;
    out_data_nxt.driver_enabled = phase_nxt != srpg_pkg::PH_IDLE;
    out_data_nxt.dir_level      = dir_nxt;
    out_data_nxt.step_level     = phase_nxt == srpg_pkg::PH_HIGH;
    out_data_nxt.busy_res       = phase_nxt != srpg_pkg::PH_IDLE;
    out_data_nxt.done_res       = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= srpg_pkg::PH_IDLE;
      tick_r      <= 16'd0;
      half_r      <= 16'd0;
      pidx_r      <= 16'd0;
      motor_r     <= 3'd0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        half_r  <= half_nxt;
        pidx_r  <= pidx_nxt;
        motor_r <= motor_nxt;
        dir_r   <= dir_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: src/srpg_checker.sv
// Port-level checker for the stepper ramp pulse generator, bound to the top level.
`default_nettype none
module srpg_port_props (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire srpg_pkg::out_t out_data
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // a finished move reports idle on the same word
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res && !out_data.driver_enabled)
    else $error("done reported while busy");

  // step line only toggles with the driver enabled
  a_step_en: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.step_level |-> out_data.driver_enabled && out_data.busy_res)
    else $error("step high with driver disabled");

  // each accepted word yields a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

endmodule

bind stepper_ramp_pulse_generator srpg_port_props u_srpg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
